[rtl/gtts_pkg.sv]
// ----------------------------------------------------------------------------
// gtts_pkg
// Shared types and codes of the gridded time table sampler: request opcodes,
// response status codes, configuration indexes, arithmetic unit modes and
// step counts, controller states and ctrl/datapath command/status bundles.
// ----------------------------------------------------------------------------
package gtts_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_TIME = 3'd0,
    OP_LOAD_NODE = 3'd1,
    OP_HOLD      = 3'd2,
    OP_INTERP    = 3'd3,
    OP_DERIV     = 3'd4,
    OP_INTEG     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_NO_MATCH = 2'd1,
    RS_EMPTY    = 2'd2,
    RS_MISMATCH = 2'd3
  } rsp_status_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_TIMES   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1
  } md_mode_t;

  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOCATE,
    S_SEARCH,
    S_V1_READ,
    S_V1_WAIT,
    S_CALC,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_INT_READ,
    S_INT_WAIT,
    S_INT_ACC,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic loc_run;
    logic srch_run;
    logic v1_rd;
    logic v1_cap;
    logic i_cap;
    logic i_inc;
    logic mul_start;
    logic div_start;
    logic acc_add;
    logic out_load;
  } gtts_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       n_one;
    logic       t_ne0;
    logic       loc_done;
    logic       loc_in;
    logic       srch_done;
    logic       matched;
    logic       i_first;
    logic       i_last;
    logic       md_busy;
    logic       out_free;
  } gtts_sts_t;

endpackage

[rtl/gtts_req_if.sv]
// ----------------------------------------------------------------------------
// gtts_req_if
// Request channel: valid/ready handshake with load and query fields.
// ----------------------------------------------------------------------------
interface gtts_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [3:0]         time_slot;
  logic [9:0]         node_slot;
  logic signed [31:0] time_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] node_value;

  modport source (output valid, op, time_slot, node_slot, time_value, x_coord,
                  y_coord, node_value, input ready);
  modport sink   (input valid, op, time_slot, node_slot, time_value, x_coord,
                  y_coord, node_value, output ready);
endinterface

[rtl/gtts_rsp_if.sv]
// ----------------------------------------------------------------------------
// gtts_rsp_if
// Response channel: valid/ready handshake with result and status.
// ----------------------------------------------------------------------------
interface gtts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

[rtl/gtts_muldiv.sv]
// ----------------------------------------------------------------------------
// gtts_muldiv
// Shared serial arithmetic unit: 34x33 shift-add multiply (one bit a cycle)
// and 64/33 restoring divide (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module gtts_muldiv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  gtts_pkg::md_mode_t     mode,
  input  logic [33:0]            mul_a,
  input  logic [32:0]            mul_b,
  input  logic [63:0]            div_n,
  input  logic [32:0]            div_d,
  output logic                   busy,
  output logic [66:0]            prod
);

  logic [6:0]         steps;
  gtts_pkg::md_mode_t mode_r;
  logic [33:0]        a_r;
  logic [32:0]        d_r;
  logic [32:0]        rem;
  logic [34:0]        psum;
  logic [33:0]        rtry;
  logic               ge;

  assign psum = {1'b0, prod[66:33]} + (prod[0] ? {1'b0, a_r} : 35'd0);
  assign rtry = {rem, prod[63]};
  assign ge   = (rtry >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= (mode == gtts_pkg::MD_MUL) ? 7'(gtts_pkg::MUL_STEPS)
                                          : 7'(gtts_pkg::DIV_STEPS);
    end else if (busy) begin
      steps <= steps - 7'd1;
      if (steps == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      a_r    <= mul_a;
      d_r    <= div_d;
      rem    <= '0;
      if (mode == gtts_pkg::MD_MUL) begin
        prod <= {34'd0, mul_b};
      end else begin
        prod <= {3'd0, div_n};
      end
    end else if (busy) begin
      if (mode_r == gtts_pkg::MD_MUL) begin
        prod <= {psum, prod[32:1]};
      end else begin
        rem  <= ge ? 33'(rtry - {1'b0, d_r}) : rtry[32:0];
        prod <= {3'd0, prod[62:0], ge};
      end
    end
  end

endmodule

[rtl/gtts_datapath.sv]
// ----------------------------------------------------------------------------
// gtts_datapath
// Table storage, configuration, time locate scan, node match scan, integral
// accumulator and response register of the sampler.
// ----------------------------------------------------------------------------
module gtts_datapath #(
  parameter int MAX_TIMES       = 16,
  parameter int MAX_NODES       = 1024,
  parameter int MATCH_TOLERANCE = 6554
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gtts_pkg::gtts_cmd_t   cmd,
  output gtts_pkg::gtts_sts_t   sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [10:0]           cfg_data,
  input  logic [2:0]            in_op,
  input  logic [3:0]            in_time_slot,
  input  logic [9:0]            in_node_slot,
  input  logic signed [31:0]    in_time_value,
  input  logic signed [31:0]    in_x_coord,
  input  logic signed [31:0]    in_y_coord,
  input  logic signed [31:0]    in_node_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_result,
  output logic [1:0]            out_status
);

  localparam int TW    = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
  localparam int NTW   = $clog2(MAX_TIMES + 1);
  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int DEPTH = MAX_TIMES * MAX_NODES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;
  localparam logic signed [71:0] HALF   = 72'sd65536;
  localparam logic [32:0]        TOL    = 33'(MATCH_TOLERANCE);

  function automatic logic [AW-1:0] node_addr(input logic [TW-1:0] slot,
                                              input logic [NW-1:0] j);
    return AW'(slot) * AW'(MAX_NODES) + AW'(j);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // configuration
  logic [10:0]        grid_columns;
  logic [10:0]        grid_rows;
  logic [4:0]         time_count;
  logic [21:0]        grid_prod;
  logic [NTW-1:0]     n_used;
  logic [NCW-1:0]     node_cnt;

  // request latch
  logic [2:0]         op_r;
  logic signed [31:0] t_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic               loaded;
  logic               empty_r;

  // storage
  logic signed [31:0] tmem [MAX_TIMES];
  logic [95:0]        nmem [DEPTH];
  logic signed [31:0] tq;
  logic [95:0]        nq;
  logic [TW-1:0]      taddr;
  logic [AW-1:0]      naddr;

  // locate scan
  logic [NTW-1:0]     tcnt;
  logic               tq_v;
  logic [TW-1:0]      tq_idx;
  logic               t_lo;
  logic               t_hi;
  logic               t_found;
  logic               t_ne0;
  logic               loc_done;
  logic [TW-1:0]      fpos;
  logic signed [31:0] tscan;
  logic signed [31:0] tpos;
  logic signed [31:0] tpos1;
  logic [TW-1:0]      pos;
  logic               loc_in;
  logic               t_issue;

  // node scan
  logic [NCW-1:0]     ncnt;
  logic               nq_v;
  logic [NW-1:0]      nq_idx;
  logic               matched;
  logic [NW-1:0]      node_r;
  logic signed [31:0] v0;
  logic signed [31:0] v1;
  logic               n_issue;
  logic [TW-1:0]      slot;
  logic [32:0]        dx_abs;
  logic [32:0]        dy_abs;
  logic               hit;

  // arithmetic
  logic [TW-1:0]      ic;
  logic signed [31:0] tprev;
  logic signed [31:0] vprev;
  logic               isign;
  logic signed [71:0] acc;
  logic signed [32:0] dv;
  logic [33:0]        dv_abs;
  logic [32:0]        num;
  logic [32:0]        dt;
  logic signed [33:0] s_sum;
  logic [33:0]        s_abs;
  logic signed [32:0] d_dif;
  logic [32:0]        d_abs;
  logic               sgn_now;
  logic [33:0]        mul_a;
  logic [32:0]        mul_b;
  logic [63:0]        div_n;
  logic               md_busy;
  logic [66:0]        md_prod;
  gtts_pkg::md_mode_t md_mode;
  logic signed [31:0] fin_res;
  logic [1:0]         fin_st;
  logic signed [71:0] interp72;
  logic signed [71:0] deriv72;
  logic signed [71:0] integ72;
  logic               is_query;

  assign grid_prod = 22'(grid_columns) * 22'(grid_rows);
  assign node_cnt  = (32'(grid_prod) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(grid_prod);
  always_comb begin
    if (time_count == 5'd0) begin
      n_used = NTW'(1);
    end else if (32'(time_count) > MAX_TIMES) begin
      n_used = NTW'(MAX_TIMES);
    end else begin
      n_used = NTW'(time_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 11'd1;
      grid_rows    <= 11'd1;
      time_count   <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        gtts_pkg::CFG_COLUMNS: grid_columns <= cfg_data;
        gtts_pkg::CFG_ROWS:    grid_rows    <= cfg_data;
        gtts_pkg::CFG_TIMES:   time_count   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // request latch and loaded flag
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded  <= 1'b0;
      empty_r <= 1'b0;
      op_r    <= '0;
    end else if (cmd.take) begin
      op_r    <= in_op;
      empty_r <= !loaded;
      if (in_op == gtts_pkg::OP_LOAD_TIME && 32'(in_time_slot) < MAX_TIMES) begin
        loaded <= 1'b1;
      end
      if (in_op == gtts_pkg::OP_LOAD_NODE && 32'(in_time_slot) < MAX_TIMES &&
          32'(in_node_slot) < MAX_NODES) begin
        loaded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      t_r <= in_time_value;
      x_r <= in_x_coord;
      y_r <= in_y_coord;
    end
  end

  // time and node storage, registered reads every cycle
  assign t_issue = cmd.loc_run && (tcnt < n_used);
  assign taddr   = cmd.loc_run ? TW'(tcnt) : ic;
  assign slot    = (op_r == gtts_pkg::OP_INTEG) ? '0 : pos;
  assign n_issue = cmd.srch_run && (NCW'(ncnt) < node_cnt) && !matched;
  always_comb begin
    if (cmd.srch_run) begin
      naddr = node_addr(slot, NW'(ncnt));
    end else if (cmd.v1_rd) begin
      naddr = node_addr(pos + TW'(1), node_r);
    end else begin
      naddr = node_addr(ic, node_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_op == gtts_pkg::OP_LOAD_TIME && 32'(in_time_slot) < MAX_TIMES) begin
      tmem[TW'(in_time_slot)] <= in_time_value;
    end
    tq <= tmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_op == gtts_pkg::OP_LOAD_NODE && 32'(in_time_slot) < MAX_TIMES &&
        32'(in_node_slot) < MAX_NODES) begin
      nmem[node_addr(TW'(in_time_slot), NW'(in_node_slot))] <=
        {in_x_coord, in_y_coord, in_node_value};
    end
    nq <= nmem[naddr];
  end

  // locate: one time point a cycle; bounds from first and last, first interval
  always_ff @(posedge clk) begin
    if (rst || cmd.take) begin
      tcnt     <= '0;
      tq_v     <= 1'b0;
      loc_done <= 1'b0;
      t_found  <= 1'b0;
      t_lo     <= 1'b0;
      t_hi     <= 1'b0;
      t_ne0    <= 1'b0;
    end else begin
      tq_v <= t_issue;
      if (t_issue) begin
        tcnt <= tcnt + NTW'(1);
      end
      if (tq_v) begin
        if (tq_idx == '0) begin
          t_lo  <= (t_r <= tq);
          t_ne0 <= (t_r != tq);
        end else if (!t_found && tscan <= t_r && t_r < tq) begin
          t_found <= 1'b1;
        end
        if (tq_idx == TW'(n_used - NTW'(1))) begin
          t_hi     <= (t_r >= tq);
          loc_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tq_idx <= TW'(tcnt);
    if (tq_v) begin
      tscan <= tq;
      if (tq_idx != '0 && !t_found && tscan <= t_r && t_r < tq) begin
        fpos  <= tq_idx - TW'(1);
        tpos  <= tscan;
        tpos1 <= tq;
      end
    end
  end

  assign loc_in = !t_lo && !t_hi && t_found;
  always_comb begin
    if (t_lo) begin
      pos = '0;
    end else if (t_hi) begin
      pos = TW'(n_used - NTW'(1));
    end else if (t_found) begin
      pos = fpos;
    end else begin
      pos = '0;
    end
  end

  // node search: first node within tolerance, one node a cycle
  assign dx_abs = abs33(33'({nq[95], nq[95:64]}) - 33'({x_r[31], x_r}));
  assign dy_abs = abs33(33'({nq[63], nq[63:32]}) - 33'({y_r[31], y_r}));
  assign hit    = (dx_abs < TOL) && (dy_abs < TOL);

  always_ff @(posedge clk) begin
    if (rst || cmd.take) begin
      ncnt    <= '0;
      nq_v    <= 1'b0;
      matched <= 1'b0;
    end else begin
      nq_v <= n_issue;
      if (n_issue) begin
        ncnt <= ncnt + NCW'(1);
      end
      if (nq_v && !matched && hit) begin
        matched <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    nq_idx <= NW'(ncnt);
    if (nq_v && !matched && hit) begin
      node_r <= nq_idx;
      v0     <= nq[31:0];
    end
    if (cmd.v1_cap) begin
      v1 <= nq[31:0];
    end
  end

  // arithmetic operands
  assign dv      = 33'({v1[31], v1}) - 33'({v0[31], v0});
  assign dv_abs  = {1'b0, abs33(dv)};
  assign num     = 33'({t_r[31], t_r}) - 33'({tpos[31], tpos});
  assign dt      = 33'({tpos1[31], tpos1}) - 33'({tpos[31], tpos});
  assign s_sum   = 34'({{2{nq[31]}}, nq[31:0]}) + 34'({{2{vprev[31]}}, vprev});
  assign s_abs   = s_sum[33] ? 34'(-s_sum) : 34'(s_sum);
  assign d_dif   = 33'({tq[31], tq}) - 33'({tprev[31], tprev});
  assign d_abs   = abs33(d_dif);
  assign sgn_now = s_sum[33] ^ d_dif[32];

  assign mul_a   = (op_r == gtts_pkg::OP_INTEG) ? s_abs : dv_abs;
  assign mul_b   = (op_r == gtts_pkg::OP_INTEG) ? d_abs : num;
  assign div_n   = (op_r == gtts_pkg::OP_INTERP) ? md_prod[63:0]
                                                 : {14'd0, dv_abs, 16'd0};
  assign md_mode = cmd.div_start ? gtts_pkg::MD_DIV : gtts_pkg::MD_MUL;

  gtts_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start || cmd.div_start),
    .mode  (md_mode),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .div_n (div_n),
    .div_d (dt),
    .busy  (md_busy),
    .prod  (md_prod)
  );

  // integral loop over time points
  always_ff @(posedge clk) begin
    if (rst || cmd.take) begin
      ic  <= '0;
      acc <= '0;
    end else begin
      if (cmd.i_inc) begin
        ic <= ic + TW'(1);
      end
      if (cmd.acc_add) begin
        acc <= isign ? acc - 72'({5'd0, md_prod}) : acc + 72'({5'd0, md_prod});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_cap) begin
      tprev <= tq;
      vprev <= nq[31:0];
    end
    if (cmd.mul_start) begin
      isign <= sgn_now;
    end
  end

  // final answer
  assign interp72 = dv[32] ? 72'(v0) - 72'({38'd0, md_prod[33:0]})
                           : 72'(v0) + 72'({38'd0, md_prod[33:0]});
  assign deriv72  = dv[32] ? -72'({8'd0, md_prod[63:0]}) : 72'({8'd0, md_prod[63:0]});
  assign integ72  = (acc + HALF) >>> 17;
  assign is_query = (op_r == gtts_pkg::OP_HOLD) || (op_r == gtts_pkg::OP_INTERP) ||
                    (op_r == gtts_pkg::OP_DERIV) || (op_r == gtts_pkg::OP_INTEG);

  always_comb begin
    fin_res = '0;
    fin_st  = gtts_pkg::RS_OK;
    if (is_query && empty_r) begin
      fin_st = gtts_pkg::RS_EMPTY;
    end else begin
      case (op_r)
        gtts_pkg::OP_HOLD: begin
          if (n_used == NTW'(1) && t_ne0) begin
            fin_st = gtts_pkg::RS_MISMATCH;
          end else if (!matched) begin
            fin_st = gtts_pkg::RS_NO_MATCH;
          end else begin
            fin_res = v0;
          end
        end
        gtts_pkg::OP_INTERP: begin
          if (!matched) begin
            fin_st = gtts_pkg::RS_NO_MATCH;
          end else if (!loc_in) begin
            fin_res = v0;
          end else begin
            fin_res = sat32(interp72);
          end
        end
        gtts_pkg::OP_DERIV: begin
          if (loc_in) begin
            if (!matched) begin
              fin_st = gtts_pkg::RS_NO_MATCH;
            end else begin
              fin_res = sat32(deriv72);
            end
          end
        end
        gtts_pkg::OP_INTEG: begin
          if (!matched) begin
            fin_st = gtts_pkg::RS_NO_MATCH;
          end else begin
            fin_res = sat32(integ72);
          end
        end
        default: ;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result <= fin_res;
      out_status <= fin_st;
    end
  end

  assign sts.op        = op_r;
  assign sts.empty     = empty_r;
  assign sts.n_one     = (n_used == NTW'(1));
  assign sts.t_ne0     = t_ne0;
  assign sts.loc_done  = loc_done;
  assign sts.loc_in    = loc_in;
  assign sts.srch_done = matched || ((ncnt >= node_cnt) && !nq_v);
  assign sts.matched   = matched;
  assign sts.i_first   = (ic == '0);
  assign sts.i_last    = (ic == TW'(n_used - NTW'(1)));
  assign sts.md_busy   = md_busy;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

[rtl/gtts_ctrl.sv]
// ----------------------------------------------------------------------------
// gtts_ctrl
// Sequencer of the sampler: takes one request at a time and steps the
// datapath through locate, search, arithmetic and response phases.
// ----------------------------------------------------------------------------
module gtts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  gtts_pkg::gtts_sts_t   sts,
  output gtts_pkg::gtts_cmd_t   cmd
);

  gtts_pkg::ctrl_state_t state;
  gtts_pkg::ctrl_state_t state_next;
  logic                  is_load;

  assign is_load = (sts.op == gtts_pkg::OP_LOAD_TIME) || (sts.op == gtts_pkg::OP_LOAD_NODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gtts_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = gtts_pkg::S_DISPATCH;
        end
      end
      gtts_pkg::S_DISPATCH: begin
        if (is_load || sts.empty || sts.op > gtts_pkg::OP_INTEG) begin
          state_next = gtts_pkg::S_FINISH;
        end else if (sts.op == gtts_pkg::OP_INTEG) begin
          state_next = gtts_pkg::S_SEARCH;
        end else begin
          state_next = gtts_pkg::S_LOCATE;
        end
      end
      gtts_pkg::S_LOCATE: begin
        if (sts.loc_done) begin
          if (sts.op == gtts_pkg::OP_HOLD && sts.n_one && sts.t_ne0) begin
            state_next = gtts_pkg::S_FINISH;
          end else if (sts.op == gtts_pkg::OP_DERIV && !sts.loc_in) begin
            state_next = gtts_pkg::S_FINISH;
          end else begin
            state_next = gtts_pkg::S_SEARCH;
          end
        end
      end
      gtts_pkg::S_SEARCH: begin
        if (sts.srch_done) begin
          if (!sts.matched || sts.op == gtts_pkg::OP_HOLD) begin
            state_next = gtts_pkg::S_FINISH;
          end else if (sts.op == gtts_pkg::OP_INTEG) begin
            state_next = sts.n_one ? gtts_pkg::S_FINISH : gtts_pkg::S_INT_READ;
          end else if (sts.loc_in) begin
            state_next = gtts_pkg::S_V1_READ;
          end else begin
            state_next = gtts_pkg::S_FINISH;
          end
        end
      end
      gtts_pkg::S_V1_READ: state_next = gtts_pkg::S_V1_WAIT;
      gtts_pkg::S_V1_WAIT: state_next = gtts_pkg::S_CALC;
      gtts_pkg::S_CALC: begin
        state_next = (sts.op == gtts_pkg::OP_INTERP) ? gtts_pkg::S_MUL : gtts_pkg::S_DIV;
      end
      gtts_pkg::S_MUL: begin
        if (!sts.md_busy) begin
          state_next = (sts.op == gtts_pkg::OP_INTEG) ? gtts_pkg::S_INT_ACC
                                                      : gtts_pkg::S_DIV_GO;
        end
      end
      gtts_pkg::S_DIV_GO: state_next = gtts_pkg::S_DIV;
      gtts_pkg::S_DIV: begin
        if (!sts.md_busy) begin
          state_next = gtts_pkg::S_FINISH;
        end
      end
      gtts_pkg::S_INT_READ: state_next = gtts_pkg::S_INT_WAIT;
      gtts_pkg::S_INT_WAIT: begin
        state_next = sts.i_first ? gtts_pkg::S_INT_READ : gtts_pkg::S_MUL;
      end
      gtts_pkg::S_INT_ACC: begin
        state_next = sts.i_last ? gtts_pkg::S_FINISH : gtts_pkg::S_INT_READ;
      end
      gtts_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_next = gtts_pkg::S_IDLE;
        end
      end
      default: state_next = gtts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      gtts_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
      end
      gtts_pkg::S_LOCATE:  cmd.loc_run  = 1'b1;
      gtts_pkg::S_SEARCH:  cmd.srch_run = 1'b1;
      gtts_pkg::S_V1_READ: cmd.v1_rd    = 1'b1;
      gtts_pkg::S_V1_WAIT: cmd.v1_cap   = 1'b1;
      gtts_pkg::S_CALC: begin
        if (sts.op == gtts_pkg::OP_INTERP) begin
          cmd.mul_start = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      gtts_pkg::S_DIV_GO: cmd.div_start = 1'b1;
      gtts_pkg::S_INT_WAIT: begin
        // first point only primes the previous sample
        cmd.i_cap = 1'b1;
        if (sts.i_first) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
        end
      end
      gtts_pkg::S_INT_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.i_inc   = !sts.i_last;
      end
      gtts_pkg::S_FINISH: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/gridded_time_table_sampler.sv]
// ----------------------------------------------------------------------------
// gridded_time_table_sampler
// Time-indexed table of gridded nodes: loads, hold sample, interpolation,
// time derivative and trapezoid integral, one request at a time.
// Loads, unknown opcodes and queries on an empty table go from dispatch to finish.
// Queries: a locate scan over the time points in use (skipped by integrate),
//   a node match scan at one node a cycle, then, where needed, multiply and
//   divide in the shared serial unit; integrate runs one multiply per interval.
// Reset clears configuration to 1 and the loaded flag; table contents are
//   undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module gridded_time_table_sampler #(
  parameter int MAX_TIMES       = 16,
  parameter int MAX_NODES       = 1024,
  parameter int MATCH_TOLERANCE = 6554
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  gtts_req_if.sink    req,
  gtts_rsp_if.source  rsp
);

  gtts_pkg::gtts_cmd_t cmd;
  gtts_pkg::gtts_sts_t sts;

  gtts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gtts_datapath #(
    .MAX_TIMES       (MAX_TIMES),
    .MAX_NODES       (MAX_NODES),
    .MATCH_TOLERANCE (MATCH_TOLERANCE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (req.op),
    .in_time_slot  (req.time_slot),
    .in_node_slot  (req.node_slot),
    .in_time_value (req.time_value),
    .in_x_coord    (req.x_coord),
    .in_y_coord    (req.y_coord),
    .in_node_value (req.node_value),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_result    (rsp.result),
    .out_status    (rsp.status)
  );

  // one request in flight: ready drops right after a request is taken
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  // any non-ok status carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != gtts_pkg::RS_OK |-> rsp.result == 32'sd0)
    else $error("error response with nonzero result");

  // a response is posted only from the finish phase, never while idle
  a_post_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("response posted while idle");

endmodule
